### design/h264nal_pkg.sv
// Shared types and constants for the H.264 Annex B NAL splitter.
// No dependencies.
package h264nal_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [4:0] NAL_TYPE_P   = 5'd1;
  localparam logic [4:0] NAL_TYPE_I   = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_NAL_END  = 2'd1,
    KIND_UNIT_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PARAM_NONE = 2'd0,
    PARAM_SPS  = 2'd1,
    PARAM_PPS  = 2'd2
  } param_e;

  // Work for one input word: optional NAL end, bytes win[first_idx..stop_idx-1],
  // optional NAL end, optional unit end report.
  typedef struct packed {
    logic            pre_end;
    logic            post_end;
    logic            unit_end;
    logic [3:0][7:0] win;
    logic [2:0]      first_idx;
    logic [2:0]      stop_idx;
  } entry_t;

endpackage

### design/h264nal_front.sv
// Start code scanner: 4-byte window, NAL tracking, empty-NAL stop.
// Emits at most one work entry per accepted input word. Depends on h264nal_pkg.
module h264nal_front import h264nal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       unit_end_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [2:0][7:0] win_q, win_d;
  logic [1:0]      wc_q, wc_d;
  logic            nal_q, nal_d;
  logic            hb_q, hb_d;
  logic            stop_q, stop_d;

  logic [3:0][7:0] w;
  logic [2:0]      cnt, keep, first, last_idx, idx;
  logic            sc, full4, pre, post, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    w = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = win_q[i];
    end
    w[wc_q] = data_byte_i;
    cnt   = {1'b0, wc_q} + 3'd1;
    full4 = (cnt == 3'd4);
    sc    = (w[0] == 8'd0) && (w[1] == 8'd0) &&
            ((w[2] == 8'd1) || ((w[2] == 8'd0) && (w[3] == 8'd1)));
    keep     = 3'd0;
    first    = 3'd0;
    last_idx = 3'd0;
    idx      = 3'd0;
    pre      = 1'b0;
    post     = 1'b0;
    nal_d    = nal_q;
    hb_d     = hb_q;
    stop_d   = stop_q;
    wc_d     = wc_q;
    win_d    = win_q;

    if (!stop_q) begin
      if (full4) begin
        if (sc) begin
          keep = (w[2] == 8'd1) ? 3'd3 : 3'd4;
          if (nal_q) begin
            if (hb_q) begin
              pre = 1'b1;
            end else begin
              stop_d = 1'b1;
            end
          end
          nal_d = !stop_d;
          hb_d  = 1'b0;
        end else begin
          keep = 3'd1;
        end
      end

      if (!stop_d) begin
        if (nal_d) begin
          first = (full4 && sc) ? keep : 3'd0;
          if (unit_end_i) begin
            last_idx = cnt;
          end else if (full4 && !sc) begin
            last_idx = 3'd1;
          end else begin
            last_idx = first;
          end
          if (last_idx != first) begin
            hb_d = 1'b1;
          end
        end
        if (unit_end_i) begin
          post = nal_d && hb_d;
        end else begin
          wc_d = 2'(cnt - keep);
          for (int i = 0; i < 3; i++) begin
            idx = keep + 3'(i);
            if (idx < 3'd4) begin
              win_d[i] = w[idx[1:0]];
            end
          end
        end
      end
    end

    if (unit_end_i) begin
      wc_d   = 2'd0;
      nal_d  = 1'b0;
      hb_d   = 1'b0;
      stop_d = 1'b0;
      win_d  = '0;
    end
  end

  always_comb begin
    entry_o.pre_end   = pre;
    entry_o.post_end  = post;
    entry_o.unit_end  = unit_end_i;
    entry_o.win       = w;
    entry_o.first_idx = first;
    entry_o.stop_idx  = last_idx;
    push_o = accept && (pre || post || unit_end_i || (last_idx != first));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      wc_q   <= '0;
      nal_q  <= 1'b0;
      hb_q   <= 1'b0;
      stop_q <= 1'b0;
    end else if (accept) begin
      win_q  <= win_d;
      wc_q   <= wc_d;
      nal_q  <= nal_d;
      hb_q   <= hb_d;
      stop_q <= stop_d;
    end
  end

endmodule

### design/h264nal_queue.sv
// Short FIFO of work entries between scanner and emitter.
// Depends on h264nal_pkg.
module h264nal_queue import h264nal_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### design/h264nal_back.sv
// Emitter: expands work entries into result words, one per cycle unless
// stalled; keeps NAL length, SPS bytes, track, sample state. Depends on h264nal_pkg.
module h264nal_back import h264nal_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  entry_t                 head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             payload_byte_o,
  output logic [4:0]             nal_type_o,
  output logic [LENGTH_BITS-1:0] length_o,
  output logic                   sample_unit_o,
  output logic [1:0]             param_kind_o,
  output logic                   track_opened_o,
  output logic [23:0]            sps_profile_bytes_o,
  output logic                   sync_sample_o,
  output logic                   write_sample_o,
  output logic                   last_o
);

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [LENGTH_BITS:0]   LenMaxX = {1'b0, LenMax};

  entry_t cur_q, cur_d, work, rem;
  logic   cur_has_q, cur_has_d, have, use_head, rem_has, fire;
  kind_e  op;
  logic [7:0] b;

  logic [LENGTH_BITS-1:0] cnt_q, cnt_d, sum_q, sum_d, len4;
  logic [LENGTH_BITS:0]   len4_x, sum_x;
  logic [4:0]             type_q, type_d;
  logic [23:0]            sps_q, sps_d;
  logic                   track_q, track_d, su_q, su_d, sync_q, sync_d;

  logic                   ov_q;
  kind_e                  kind_q, kind_d;
  logic [7:0]             byte_q, byte_d;
  logic [4:0]             ntype_q, ntype_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   su_out_q, su_out_d;
  param_e                 pk_q, pk_d;
  logic                   to_q, to_d, syncs_q, syncs_d, ws_q, ws_d, last_q;
  logic [23:0]            sps_out_q, sps_out_d;

  always_comb begin
    use_head = !cur_has_q && !empty_i;
    have     = cur_has_q || !empty_i;
    work     = cur_has_q ? cur_q : head_i;
    rem      = work;
    b        = work.win[work.first_idx[1:0]];
    if (work.pre_end) begin
      op          = KIND_NAL_END;
      rem.pre_end = 1'b0;
    end else if (work.first_idx != work.stop_idx) begin
      op            = KIND_PAYLOAD;
      rem.first_idx = work.first_idx + 3'd1;
    end else if (work.post_end) begin
      op           = KIND_NAL_END;
      rem.post_end = 1'b0;
    end else begin
      op           = KIND_UNIT_END;
      rem.unit_end = 1'b0;
    end
    rem_has = rem.pre_end || rem.post_end || rem.unit_end ||
              (rem.first_idx != rem.stop_idx);
    fire  = have && (!ov_q || out_ready_i);
    pop_o = fire && use_head;
    cur_d     = fire ? rem : cur_q;
    cur_has_d = fire ? rem_has : cur_has_q;
  end

  always_comb begin
    len4_x = {1'b0, cnt_q} + (LENGTH_BITS+1)'(4);
    len4   = (len4_x > LenMaxX) ? LenMax : len4_x[LENGTH_BITS-1:0];
    sum_x  = {1'b0, sum_q} + {1'b0, len4};

    cnt_d   = cnt_q;
    sum_d   = sum_q;
    type_d  = type_q;
    sps_d   = sps_q;
    track_d = track_q;
    su_d    = su_q;
    sync_d  = sync_q;

    kind_d    = op;
    byte_d    = '0;
    ntype_d   = '0;
    len_d     = '0;
    su_out_d  = 1'b0;
    pk_d      = PARAM_NONE;
    to_d      = 1'b0;
    syncs_d   = 1'b0;
    ws_d      = 1'b0;
    sps_out_d = '0;

    unique case (op)
      KIND_PAYLOAD: begin
        if (cnt_q == '0) begin
          type_d = b[4:0];
        end else if (cnt_q == LENGTH_BITS'(1)) begin
          sps_d[23:16] = b;
        end else if (cnt_q == LENGTH_BITS'(2)) begin
          sps_d[15:8] = b;
        end else if (cnt_q == LENGTH_BITS'(3)) begin
          sps_d[7:0] = b;
        end
        cnt_d   = (cnt_q == LenMax) ? cnt_q : cnt_q + 1'b1;
        byte_d  = b;
        ntype_d = type_d;
      end
      KIND_NAL_END: begin
        ntype_d = type_q;
        len_d   = cnt_q;
        if (type_q == NAL_TYPE_SPS) begin
          if (cnt_q >= LENGTH_BITS'(4)) begin
            sps_out_d = sps_q;
            if (!track_q) begin
              track_d = 1'b1;
              to_d    = 1'b1;
            end
          end
          if (track_d) begin
            pk_d = PARAM_SPS;
          end
        end else if (type_q == NAL_TYPE_PPS) begin
          if (track_q) begin
            pk_d = PARAM_PPS;
          end
        end else if (type_q == NAL_TYPE_P || type_q == NAL_TYPE_I) begin
          su_out_d = 1'b1;
          su_d     = 1'b1;
          if (type_q == NAL_TYPE_I) begin
            sync_d = 1'b1;
          end
          sum_d = (sum_x > LenMaxX) ? LenMax : sum_x[LENGTH_BITS-1:0];
        end
        cnt_d  = '0;
        type_d = '0;
        sps_d  = '0;
      end
      KIND_UNIT_END: begin
        len_d   = sum_q;
        syncs_d = sync_q;
        ws_d    = track_q && su_q;
        cnt_d   = '0;
        sum_d   = '0;
        type_d  = '0;
        sps_d   = '0;
        su_d    = 1'b0;
        sync_d  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_has_q <= 1'b0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      sum_q     <= '0;
      type_q    <= '0;
      sps_q     <= '0;
      track_q   <= 1'b0;
      su_q      <= 1'b0;
      sync_q    <= 1'b0;
    end else begin
      cur_has_q <= cur_has_d;
      if (fire) begin
        ov_q    <= 1'b1;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        type_q  <= type_d;
        sps_q   <= sps_d;
        track_q <= track_d;
        su_q    <= su_d;
        sync_q  <= sync_d;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (fire) begin
      kind_q    <= kind_d;
      byte_q    <= byte_d;
      ntype_q   <= ntype_d;
      len_q     <= len_d;
      su_out_q  <= su_out_d;
      pk_q      <= pk_d;
      to_q      <= to_d;
      syncs_q   <= syncs_d;
      ws_q      <= ws_d;
      sps_out_q <= sps_out_d;
      last_q    <= !rem_has;
    end
  end

  assign out_valid_o         = ov_q;
  assign kind_o              = kind_q;
  assign payload_byte_o      = byte_q;
  assign nal_type_o          = ntype_q;
  assign length_o            = len_q;
  assign sample_unit_o       = su_out_q;
  assign param_kind_o        = pk_q;
  assign track_opened_o      = to_q;
  assign sps_profile_bytes_o = sps_out_q;
  assign sync_sample_o       = syncs_q;
  assign write_sample_o      = ws_q;
  assign last_o              = last_q;

endmodule

### design/h264_annexb_nal_splitter.sv
// H.264 Annex B NAL splitter, top level: scanner, work queue, emitter.
// Registered path: byte -> queue entry -> emitter output registers.
// Throughput, output not stalled: one input byte per cycle while each byte
// yields at most one result; emitter: one word per cycle, up to 6 per byte.
// Reset (rst_ni low, asynchronous) clears window, NAL, sample and track state.
// Depends on h264nal_pkg, h264nal_front, h264nal_queue, h264nal_back.
module h264_annexb_nal_splitter import h264nal_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   unit_end_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             payload_byte_o,
  output logic [4:0]             nal_type_o,
  output logic [LENGTH_BITS-1:0] length_o,
  output logic                   sample_unit_o,
  output logic [1:0]             param_kind_o,
  output logic                   track_opened_o,
  output logic [23:0]            sps_profile_bytes_o,
  output logic                   sync_sample_o,
  output logic                   write_sample_o,
  output logic                   last_o
);

  entry_t push_entry, head;
  logic   push, pop, full, empty;

  h264nal_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .unit_end_i  (unit_end_i),
    .q_full_i    (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  h264nal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  h264nal_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .empty_i             (empty),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .payload_byte_o      (payload_byte_o),
    .nal_type_o          (nal_type_o),
    .length_o            (length_o),
    .sample_unit_o       (sample_unit_o),
    .param_kind_o        (param_kind_o),
    .track_opened_o      (track_opened_o),
    .sps_profile_bytes_o (sps_profile_bytes_o),
    .sync_sample_o       (sync_sample_o),
    .write_sample_o      (write_sample_o),
    .last_o              (last_o)
  );

endmodule
